// ===== src/fbpa_pkg.sv =====
package fbpa_pkg;

    localparam int OFFSET_W      = 16;
    localparam int COUNT_W       = 11;
    localparam int STATUS_W      = 2;
    localparam int SIZE_W        = 5;
    localparam int M_TDATA_W     = 40;
    localparam int OFFSET_SPACE  = 65536;

    localparam int POOL_BYTES_DEF = 65536;
    localparam int MAX_BLOCKS_DEF = 1024;

    localparam logic [SIZE_W-1:0]  SIZE_LOG2_MIN   = 5'd6;
    localparam logic [SIZE_W-1:0]  SIZE_LOG2_MAX   = 5'd16;
    localparam logic [SIZE_W-1:0]  SIZE_LOG2_RESET = 5'd9;
    localparam logic [COUNT_W-1:0] COUNT_MAX       = 11'd2047;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK         = 2'd0,
        STATUS_EMPTY      = 2'd1,
        STATUS_BAD_OFFSET = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ALLOC
    } state_t;

    typedef struct packed {
        logic [COUNT_W-1:0]  peak_open;
        logic [COUNT_W-1:0]  open_count;
        logic [OFFSET_W-1:0] block_offset;
    } result_t;

endpackage

// ===== src/fixed_block_pool_allocator.sv =====
// free, or allocate on an empty list: result registered in the cycle after the beat;
// other allocates: registered link-memory read, then ST_ALLOC (waits for a free
// result slot), then the result register. throughput: one free per cycle while the
// result slot is free; an allocate holds off input until its result is registered.
// reset (and every block-size write) starts a clearing pass that rebuilds the
// free list, one link a cycle, during which no item is taken. counts clear only on reset.
module fixed_block_pool_allocator #(
    parameter int POOL_BYTES = fbpa_pkg::POOL_BYTES_DEF,
    parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [fbpa_pkg::OFFSET_W-1:0]  s_tdata,   // free_offset
    input  logic                           s_tuser,   // req_type
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [fbpa_pkg::M_TDATA_W-1:0] m_tdata,   // block_offset, open_count, peak_open
    output logic [fbpa_pkg::STATUS_W-1:0]  m_tuser,   // status
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [fbpa_pkg::SIZE_W-1:0]    cfg_data   // block_size_log2
);

    localparam int IDX_W  = $clog2(MAX_BLOCKS);
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int POOL_W = $clog2(POOL_BYTES + 1);
    localparam int CMP_W  = (POOL_W > 17) ? POOL_W : 17;

    localparam int OW = fbpa_pkg::OFFSET_W;
    localparam int CW = fbpa_pkg::COUNT_W;

    fbpa_pkg::state_t                 state_reg, state_next;
    logic [fbpa_pkg::SIZE_W-1:0]      size_reg;
    logic [CNT_W-1:0]                 clr_cnt_reg, clr_cnt_next;
    logic [IDX_W-1:0]                 head_reg, head_next;
    logic                             head_ok_reg, head_ok_next;
    logic [CW-1:0]                    open_reg, open_next;
    logic [CW-1:0]                    peak_reg, peak_next;
    logic                             m_valid_reg, m_valid_next;
    fbpa_pkg::status_t                m_status_reg, m_status_next;
    fbpa_pkg::result_t                m_result_reg, m_result_next;

    logic [fbpa_pkg::SIZE_W-1:0]      shift_s;
    logic [CMP_W-1:0]                 pool_n, fit_n, min_n;
    logic [CNT_W-1:0]                 blk_cnt;

    logic                             wr_en, rd_en;
    logic [IDX_W-1:0]                 wr_addr;
    logic [IDX_W:0]                   wr_data, rd_data;
    logic [CNT_W-1:0]                 clr_plus;

    logic [OW-1:0]                    off_idx;
    logic                             free_ok;
    logic                             out_free;
    logic [CW-1:0]                    open_inc;

    fbpa_link_ram #(
        .DEPTH  (MAX_BLOCKS),
        .ADDR_W (IDX_W),
        .DATA_W (IDX_W + 1)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (head_reg),
        .rd_data (rd_data)
    );

    // clamp block size and work out how many blocks the pool holds
    always_comb begin
        if (size_reg < fbpa_pkg::SIZE_LOG2_MIN) begin
            shift_s = fbpa_pkg::SIZE_LOG2_MIN;
        end else if (size_reg > fbpa_pkg::SIZE_LOG2_MAX) begin
            shift_s = fbpa_pkg::SIZE_LOG2_MAX;
        end else begin
            shift_s = size_reg;
        end
        pool_n = CMP_W'(POOL_BYTES) >> shift_s;
        fit_n  = CMP_W'(fbpa_pkg::OFFSET_SPACE) >> shift_s;
        min_n  = (pool_n < fit_n) ? pool_n : fit_n;
        if (min_n > CMP_W'(MAX_BLOCKS)) begin
            min_n = CMP_W'(MAX_BLOCKS);
        end
        blk_cnt = CNT_W'(min_n);
    end

    assign off_idx  = s_tdata >> shift_s;
    assign free_ok  = ((off_idx << shift_s) == s_tdata)
                      && (CMP_W'(off_idx) < CMP_W'(blk_cnt))
                      && (open_reg != '0);
    assign out_free = !m_valid_reg || m_tready;
    assign open_inc = (open_reg == fbpa_pkg::COUNT_MAX) ? open_reg : open_reg + 1'b1;
    assign clr_plus = clr_cnt_reg + 1'b1;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == fbpa_pkg::ST_IDLE) && out_free;

    always_comb begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        head_next     = head_reg;
        head_ok_next  = head_ok_reg;
        open_next     = open_reg;
        peak_next     = peak_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_status_next = m_status_reg;
        m_result_next = m_result_reg;
        wr_en         = 1'b0;
        wr_addr       = clr_cnt_reg[IDX_W-1:0];
        wr_data       = {clr_plus < blk_cnt, IDX_W'(clr_plus)};
        rd_en         = 1'b0;

        unique case (state_reg)
            fbpa_pkg::ST_CLEAR: begin
                if (clr_cnt_reg < blk_cnt) begin
                    wr_en        = 1'b1;
                    clr_cnt_next = clr_plus;
                end else begin
                    head_next    = '0;
                    head_ok_next = (blk_cnt != '0);
                    state_next   = fbpa_pkg::ST_IDLE;
                end
            end
            fbpa_pkg::ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    if (!s_tuser) begin
                        if (!head_ok_reg || (CNT_W'(head_reg) >= blk_cnt)) begin
                            m_valid_next  = 1'b1;
                            m_status_next = fbpa_pkg::STATUS_EMPTY;
                            m_result_next = '{peak_open: peak_reg, open_count: open_reg,
                                              block_offset: '0};
                        end else begin
                            rd_en      = 1'b1;
                            state_next = fbpa_pkg::ST_ALLOC;
                        end
                    end else if (free_ok) begin
                        wr_en         = 1'b1;
                        wr_addr       = off_idx[IDX_W-1:0];
                        wr_data       = {head_ok_reg, head_reg};
                        head_next     = off_idx[IDX_W-1:0];
                        head_ok_next  = 1'b1;
                        open_next     = open_reg - 1'b1;
                        m_valid_next  = 1'b1;
                        m_status_next = fbpa_pkg::STATUS_OK;
                        m_result_next = '{peak_open: peak_reg, open_count: open_reg - 1'b1,
                                          block_offset: s_tdata};
                    end else begin
                        m_valid_next  = 1'b1;
                        m_status_next = fbpa_pkg::STATUS_BAD_OFFSET;
                        m_result_next = '{peak_open: peak_reg, open_count: open_reg,
                                          block_offset: '0};
                    end
                end
            end
            fbpa_pkg::ST_ALLOC: begin
                // link read of the head is back; pop it once the result slot is free
                if (out_free) begin
                    head_next     = rd_data[IDX_W-1:0];
                    head_ok_next  = rd_data[IDX_W];
                    open_next     = open_inc;
                    peak_next     = (open_inc > peak_reg) ? open_inc : peak_reg;
                    m_valid_next  = 1'b1;
                    m_status_next = fbpa_pkg::STATUS_OK;
                    m_result_next = '{peak_open: (open_inc > peak_reg) ? open_inc : peak_reg,
                                      open_count: open_inc,
                                      block_offset: OW'(head_reg) << shift_s};
                    state_next    = fbpa_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = fbpa_pkg::ST_CLEAR;
            end
        endcase

        // a block-size write rebuilds the list
        if (cfg_valid && cfg_ready) begin
            state_next   = fbpa_pkg::ST_CLEAR;
            clr_cnt_next = '0;
            head_next    = '0;
            head_ok_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= fbpa_pkg::ST_CLEAR;
            size_reg    <= fbpa_pkg::SIZE_LOG2_RESET;
            clr_cnt_reg <= '0;
            head_reg    <= '0;
            head_ok_reg <= 1'b0;
            open_reg    <= '0;
            peak_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            head_reg    <= head_next;
            head_ok_reg <= head_ok_next;
            open_reg    <= open_next;
            peak_reg    <= peak_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                size_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_status_reg <= m_status_next;
        m_result_reg <= m_result_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {{(fbpa_pkg::M_TDATA_W - $bits(fbpa_pkg::result_t)){1'b0}},
                       m_result_reg};

endmodule

// ===== src/fbpa_link_ram.sv =====
module fbpa_link_ram #(
    parameter int DEPTH  = fbpa_pkg::MAX_BLOCKS_DEF,
    parameter int ADDR_W = $clog2(DEPTH),
    parameter int DATA_W = ADDR_W + 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/fbpa_checker.sv =====
module fbpa_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [fbpa_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [fbpa_pkg::STATUS_W-1:0]  m_tuser
);

    localparam int OW = fbpa_pkg::OFFSET_W;
    localparam int CW = fbpa_pkg::COUNT_W;

    // peak never trails the open count it reports with
    a_peak_ge_open: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[OW+2*CW-1:OW+CW] >= m_tdata[OW+CW-1:OW]))
        else $error("peak_open below open_count");

    // failed requests carry a zero offset
    a_fail_zero_off: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == fbpa_pkg::STATUS_EMPTY
                      || m_tuser == fbpa_pkg::STATUS_BAD_OFFSET))
        |-> (m_tdata[OW-1:0] == '0))
        else $error("nonzero offset on failed request");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == fbpa_pkg::STATUS_OK || m_tuser == fbpa_pkg::STATUS_EMPTY
                      || m_tuser == fbpa_pkg::STATUS_BAD_OFFSET))
        else $error("undefined status code");

    // the list rebuild after reset holds off input
    a_reset_busy: assert property (@(posedge aclk)
        !aresetn |=> !s_tready && !m_tvalid)
        else $error("busy after reset not honored");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result beat changed");

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
